>>> src/amsg_pkg.sv
// amsg_pkg: shared types, command/status/action codes and reset values
// for the actuator move stall guard; no dependencies
package amsg_pkg;

	// widths fixed by the interface
	localparam int TICK_BITS        = 16;
	localparam int CUR_BITS         = 16;
	localparam int TOL_BITS         = 8;
	localparam int CFG_DATA_BITS    = 16;
	localparam int CFG_INDEX_BITS   = 3;

	// defaults for the top-level parameters
	localparam int POSITION_BITS_DEF = 12;
	localparam int PROGRESS_STEP_DEF = 2;

	// register reset values
	localparam int TARGET_RESET = 2836;
	localparam logic [TOL_BITS-1:0]  TOL_RESET        = 8'd10;
	localparam logic [CUR_BITS-1:0]  HI_CUR_RESET     = 16'd3000;
	localparam logic [CUR_BITS-1:0]  ABS_CUR_RESET    = 16'd4750;
	localparam logic [TICK_BITS-1:0] STALL_RESET      = 16'd250;
	localparam logic [TICK_BITS-1:0] HI_STALL_RESET   = 16'd150;
	localparam logic [TICK_BITS-1:0] MOVE_LIMIT_RESET = 16'd750;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_SAMPLE    = 3'd1,
		CMD_TICK      = 3'd2,
		CMD_ABORT     = 3'd3,
		CMD_READ_FAIL = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_RUNNING    = 3'd0,
		ST_REACHED    = 3'd1,
		ST_ABORT      = 3'd2,
		ST_ABS_CUR    = 3'd3,
		ST_HI_STALL   = 3'd4,
		ST_NO_PROG    = 3'd5,
		ST_TIMEOUT    = 3'd6,
		ST_READ_FAIL  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_TARGET  = 2'd1,
		ACT_NEUTRAL = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_TARGET     = 3'd0,
		REG_TOLERANCE  = 3'd1,
		REG_HI_CUR     = 3'd2,
		REG_ABS_CUR    = 3'd3,
		REG_STALL      = 3'd4,
		REG_HI_STALL   = 3'd5,
		REG_MOVE_LIMIT = 3'd6,
		REG_FAULT_MODE = 3'd7
	} cfg_idx_t;

	// limits that do not depend on the position width
	typedef struct packed {
		logic [TOL_BITS-1:0]  reach_tolerance;
		logic [CUR_BITS-1:0]  high_current_limit;
		logic [CUR_BITS-1:0]  absolute_current_limit;
		logic [TICK_BITS-1:0] stall_ticks;
		logic [TICK_BITS-1:0] high_current_stall_ticks;
		logic [TICK_BITS-1:0] move_limit_ticks;
		logic                 fault_to_neutral;
	} limits_t;

	// control part of one result item
	typedef struct packed {
		status_t status;
		action_t action;
		logic    done;
	} res_ctrl_t;

endpackage

>>> src/amsg_eval.sv
// amsg_eval: single-pass evaluation of one item against the move state,
// giving the next state and the result item; uses amsg_pkg
module amsg_eval import amsg_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int PROGRESS_STEP = PROGRESS_STEP_DEF
) (
	input  logic [2:0]               cmd,
	input  logic [CUR_BITS-1:0]      motor_current,
	input  logic [POSITION_BITS-1:0] position,
	input  logic [POSITION_BITS-1:0] target,
	input  limits_t                  limits,
	input  logic                     busy,
	input  logic                     moving_up,
	input  logic [POSITION_BITS-1:0] anchor,
	input  logic [CUR_BITS-1:0]      peak,
	input  logic [POSITION_BITS-1:0] pos_seen,
	input  logic [TICK_BITS-1:0]     tsp,
	input  logic [TICK_BITS-1:0]     tss,
	output logic                     busy_n,
	output logic                     moving_up_n,
	output logic [POSITION_BITS-1:0] anchor_n,
	output logic [CUR_BITS-1:0]      peak_n,
	output logic [POSITION_BITS-1:0] pos_seen_n,
	output logic [TICK_BITS-1:0]     tsp_n,
	output logic [TICK_BITS-1:0]     tss_n,
	output logic                     has_res,
	output res_ctrl_t                res_ctrl
);

	logic [POSITION_BITS-1:0] err;
	logic [POSITION_BITS:0]   prog;
	logic                     advanced;
	logic                     backed;
	logic [TICK_BITS-1:0]     tsp_after;
	logic [CUR_BITS-1:0]      peak_max;
	action_t                  end_act;

	// distance to target and progress against the anchor
	always_comb begin
		err = (target >= position) ? (target - position) : (position - target);
		prog = moving_up ? ({1'b0, position} - {1'b0, anchor})
		                 : ({1'b0, anchor} - {1'b0, position});
		backed = prog[POSITION_BITS];
		advanced = !prog[POSITION_BITS] &&
		           (prog[POSITION_BITS-1:0] >= POSITION_BITS'(PROGRESS_STEP));
		tsp_after = advanced ? '0 : tsp;
		peak_max = (motor_current > peak) ? motor_current : peak;
		end_act = limits.fault_to_neutral ? ACT_NEUTRAL : ACT_STOP;
	end

	// next state and result
	always_comb begin
		busy_n = busy;
		moving_up_n = moving_up;
		anchor_n = anchor;
		peak_n = peak;
		pos_seen_n = pos_seen;
		tsp_n = tsp;
		tss_n = tss;
		has_res = 1'b0;
		res_ctrl = '{status: ST_RUNNING, action: ACT_NONE, done: 1'b0};
		case (cmd_t'(cmd))
			CMD_START: begin
				busy_n = 1'b1;
				peak_n = motor_current;
				pos_seen_n = position;
				moving_up_n = (target >= position);
				anchor_n = position;
				tsp_n = '0;
				tss_n = '0;
				has_res = 1'b1;
				res_ctrl = '{status: ST_RUNNING, action: ACT_TARGET, done: 1'b0};
			end
			CMD_SAMPLE: begin
				if (busy) begin
					has_res = 1'b1;
					pos_seen_n = position;
					peak_n = peak_max;
					if (err <= POSITION_BITS'(limits.reach_tolerance)) begin
						busy_n = 1'b0;
						res_ctrl = '{status: ST_REACHED, action: ACT_NONE, done: 1'b1};
					end else begin
						if (advanced || backed) begin
							anchor_n = position;
						end
						tsp_n = tsp_after;
						// faults in priority order
						if (motor_current >= limits.absolute_current_limit) begin
							busy_n = 1'b0;
							res_ctrl = '{status: ST_ABS_CUR, action: end_act, done: 1'b1};
						end else if (motor_current >= limits.high_current_limit &&
						             tsp_after >= limits.high_current_stall_ticks) begin
							busy_n = 1'b0;
							res_ctrl = '{status: ST_HI_STALL, action: end_act, done: 1'b1};
						end else if (tsp_after >= limits.stall_ticks) begin
							busy_n = 1'b0;
							res_ctrl = '{status: ST_NO_PROG, action: end_act, done: 1'b1};
						end else if (tss >= limits.move_limit_ticks) begin
							busy_n = 1'b0;
							res_ctrl = '{status: ST_TIMEOUT, action: end_act, done: 1'b1};
						end
					end
				end
			end
			CMD_TICK: begin
				// saturating counters
				if (busy) begin
					tsp_n = (tsp == '1) ? tsp : tsp + TICK_BITS'(1);
					tss_n = (tss == '1) ? tss : tss + TICK_BITS'(1);
				end
			end
			CMD_ABORT: begin
				if (busy) begin
					busy_n = 1'b0;
					has_res = 1'b1;
					res_ctrl = '{status: ST_ABORT, action: end_act, done: 1'b1};
				end
			end
			CMD_READ_FAIL: begin
				// ends a move, or reports a failed start read when idle
				busy_n = 1'b0;
				has_res = 1'b1;
				res_ctrl = '{status: ST_READ_FAIL, action: end_act, done: 1'b1};
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

endmodule

>>> src/actuator_move_stall_guard.sv
// actuator_move_stall_guard: top level with input register, move state,
// configuration registers and result register; uses amsg_pkg and amsg_eval

// Supervises one actuator move. Items enter an input register, are
// evaluated against the move state in one pass and leave through a result
// register, and one item is taken every cycle as long as the result
// register drains. The only back-pressure comes from that single result
// register: an item that gives a result waits in the input register while
// an earlier result is still untaken; ticks and ignored items pass through
// regardless.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// and should only change while no item is in flight.
module actuator_move_stall_guard import amsg_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int PROGRESS_STEP = PROGRESS_STEP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [2:0]                cmd,
	input  logic [CUR_BITS-1:0]       motor_current,
	input  logic [POSITION_BITS-1:0]  position,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [2:0]                status,
	output logic [1:0]                action,
	output logic [CUR_BITS-1:0]       peak_current,
	output logic [POSITION_BITS-1:0]  last_position,
	output logic                      done_res
);

	logic [POSITION_BITS-1:0] target_q;
	limits_t                  limits_q;

	logic                     valid_s1;
	logic [2:0]               cmd_s1;
	logic [CUR_BITS-1:0]      cur_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	logic                     busy_q;
	logic                     moving_up_q;
	logic [POSITION_BITS-1:0] anchor_q;
	logic [CUR_BITS-1:0]      peak_q;
	logic [POSITION_BITS-1:0] pos_seen_q;
	logic [TICK_BITS-1:0]     tsp_q;
	logic [TICK_BITS-1:0]     tss_q;

	logic                     busy_n;
	logic                     moving_up_n;
	logic [POSITION_BITS-1:0] anchor_n;
	logic [CUR_BITS-1:0]      peak_n;
	logic [POSITION_BITS-1:0] pos_seen_n;
	logic [TICK_BITS-1:0]     tsp_n;
	logic [TICK_BITS-1:0]     tss_n;
	logic                     has_res;
	res_ctrl_t                res_ctrl;

	logic                     res_valid_q;
	res_ctrl_t                res_ctrl_q;
	logic [CUR_BITS-1:0]      res_peak_q;
	logic [POSITION_BITS-1:0] res_pos_q;
	logic                     advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= POSITION_BITS'(TARGET_RESET);
			limits_q <= '{reach_tolerance: TOL_RESET,
			              high_current_limit: HI_CUR_RESET,
			              absolute_current_limit: ABS_CUR_RESET,
			              stall_ticks: STALL_RESET,
			              high_current_stall_ticks: HI_STALL_RESET,
			              move_limit_ticks: MOVE_LIMIT_RESET,
			              fault_to_neutral: 1'b1};
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_TARGET:     target_q <= cfg_data[POSITION_BITS-1:0];
				REG_TOLERANCE:  limits_q.reach_tolerance <= cfg_data[TOL_BITS-1:0];
				REG_HI_CUR:     limits_q.high_current_limit <= cfg_data;
				REG_ABS_CUR:    limits_q.absolute_current_limit <= cfg_data;
				REG_STALL:      limits_q.stall_ticks <= cfg_data;
				REG_HI_STALL:   limits_q.high_current_stall_ticks <= cfg_data;
				REG_MOVE_LIMIT: limits_q.move_limit_ticks <= cfg_data;
				REG_FAULT_MODE: limits_q.fault_to_neutral <= cfg_data[0];
				default: begin
					limits_q <= limits_q;
				end
			endcase
		end
	end

	// an item leaves the input register unless its result would collide
	assign advance = valid_s1 && (!has_res || !res_valid_q || res_ready);
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1 <= cmd;
			cur_s1 <= motor_current;
			pos_s1 <= position;
		end
	end

	amsg_eval #(
		.POSITION_BITS(POSITION_BITS),
		.PROGRESS_STEP(PROGRESS_STEP)
	) u_eval (
		.cmd           (cmd_s1),
		.motor_current (cur_s1),
		.position      (pos_s1),
		.target        (target_q),
		.limits        (limits_q),
		.busy          (busy_q),
		.moving_up     (moving_up_q),
		.anchor        (anchor_q),
		.peak          (peak_q),
		.pos_seen      (pos_seen_q),
		.tsp           (tsp_q),
		.tss           (tss_q),
		.busy_n        (busy_n),
		.moving_up_n   (moving_up_n),
		.anchor_n      (anchor_n),
		.peak_n        (peak_n),
		.pos_seen_n    (pos_seen_n),
		.tsp_n         (tsp_n),
		.tss_n         (tss_n),
		.has_res       (has_res),
		.res_ctrl      (res_ctrl)
	);

	// move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			moving_up_q <= 1'b0;
			anchor_q <= '0;
			peak_q <= '0;
			pos_seen_q <= '0;
			tsp_q <= '0;
			tss_q <= '0;
		end else if (advance) begin
			busy_q <= busy_n;
			moving_up_q <= moving_up_n;
			anchor_q <= anchor_n;
			peak_q <= peak_n;
			pos_seen_q <= pos_seen_n;
			tsp_q <= tsp_n;
			tss_q <= tss_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_ctrl_q <= res_ctrl;
			res_peak_q <= peak_n;
			res_pos_q <= pos_seen_n;
		end
	end

	assign res_valid = res_valid_q;
	assign status = res_ctrl_q.status;
	assign action = res_ctrl_q.action;
	assign done_res = res_ctrl_q.done;
	assign peak_current = res_peak_q;
	assign last_position = res_pos_q;

`ifndef SYNTH
	// a pending result always matches the current move state
	a_busy_matches_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (busy_q != res_ctrl_q.done))
		else $error("pending result disagrees with move state");

	// progress counter never runs ahead of the move counter
	a_tick_order: assert property (@(posedge clk) disable iff (!arst_n)
		tsp_q <= tss_q)
		else $error("stall counter exceeds move counter");

	// command target only comes with a running start result
	a_target_running: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_ctrl_q.action == ACT_TARGET) |->
		(res_ctrl_q.status == ST_RUNNING && !res_ctrl_q.done))
		else $error("command target on a finished result");
`endif

endmodule

>>> verif/move_guard_checker.sv
`timescale 1ns / 1ps
// move_guard_checker: watches the register, item and result ports of
// actuator_move_stall_guard, predicts each report and compares it field by field
// depends on amsg_pkg
module move_guard_checker import amsg_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                            item_valid,
	input  logic                            item_ready,
	input  logic [2:0]                      cmd,
	input  logic [CUR_BITS-1:0]             motor_current,
	input  logic [POSITION_BITS_DEF-1:0]    position,
	input  logic                            res_valid,
	input  logic                            res_ready,
	input  logic [2:0]                      status,
	input  logic [1:0]                      action,
	input  logic [CUR_BITS-1:0]             peak_current,
	input  logic [POSITION_BITS_DEF-1:0]    last_position,
	input  logic                            done_res,
	output int                              reports_owed,
	output int                              report_errors
);

	localparam int POS_W = POSITION_BITS_DEF;
	localparam int STEP  = PROGRESS_STEP_DEF;
	localparam logic [TICK_BITS-1:0] TICK_SAT = '1;

	typedef struct packed {
		status_t             status;
		action_t             action;
		logic [CUR_BITS-1:0] peak;
		logic [POS_W-1:0]    pos;
		logic                done;
	} move_report_t;

	move_report_t pending_reports[$];

	// register copy
	logic [POS_W-1:0] target;
	limits_t          lim;

	// move state
	logic                 busy;
	logic                 moving_up;
	logic [POS_W-1:0]     anchor;
	logic [POS_W-1:0]     pos_seen;
	logic [CUR_BITS-1:0]  peak_seen;
	logic [TICK_BITS-1:0] since_progress;
	logic [TICK_BITS-1:0] since_start;

	function automatic move_report_t report_of(status_t st, action_t act, logic done);
		move_report_t r;
		r.status = st;
		r.action = act;
		r.peak = peak_seen;
		r.pos = pos_seen;
		r.done = done;
		return r;
	endfunction

	function automatic action_t end_action();
		return lim.fault_to_neutral ? ACT_NEUTRAL : ACT_STOP;
	endfunction

	// advance the move state by one item; returns 1 when a report is due
	function automatic bit supervise_step(input logic [2:0] c, input logic [CUR_BITS-1:0] cur,
			input logic [POS_W-1:0] pos, output move_report_t r);
		int err;
		int progress;
		status_t fault;
		r = '0;
		case (c)
			CMD_START: begin
				busy = 1'b1;
				peak_seen = cur;
				pos_seen = pos;
				moving_up = (target >= pos);
				anchor = pos;
				since_progress = '0;
				since_start = '0;
				r = report_of(ST_RUNNING, ACT_TARGET, 1'b0);
				return 1'b1;
			end
			CMD_SAMPLE: begin
				if (!busy)
					return 1'b0;
				pos_seen = pos;
				if (cur > peak_seen)
					peak_seen = cur;
				err = (target > pos) ? int'(target) - int'(pos) : int'(pos) - int'(target);
				if (err <= int'(lim.reach_tolerance)) begin
					busy = 1'b0;
					r = report_of(ST_REACHED, ACT_NONE, 1'b1);
					return 1'b1;
				end
				// anchor moves on real progress and follows any reversal
				progress = moving_up ? int'(pos) - int'(anchor) : int'(anchor) - int'(pos);
				if (progress >= STEP) begin
					anchor = pos;
					since_progress = '0;
				end else if (progress < 0) begin
					anchor = pos;
				end
				// faults by priority
				fault = ST_RUNNING;
				if (cur >= lim.absolute_current_limit)
					fault = ST_ABS_CUR;
				else if (cur >= lim.high_current_limit &&
						since_progress >= lim.high_current_stall_ticks)
					fault = ST_HI_STALL;
				else if (since_progress >= lim.stall_ticks)
					fault = ST_NO_PROG;
				else if (since_start >= lim.move_limit_ticks)
					fault = ST_TIMEOUT;
				if (fault == ST_RUNNING) begin
					r = report_of(ST_RUNNING, ACT_NONE, 1'b0);
				end else begin
					busy = 1'b0;
					r = report_of(fault, end_action(), 1'b1);
				end
				return 1'b1;
			end
			CMD_TICK: begin
				if (busy) begin
					if (since_progress != TICK_SAT)
						since_progress = since_progress + 1'b1;
					if (since_start != TICK_SAT)
						since_start = since_start + 1'b1;
				end
				return 1'b0;
			end
			CMD_ABORT: begin
				if (!busy)
					return 1'b0;
				busy = 1'b0;
				r = report_of(ST_ABORT, end_action(), 1'b1);
				return 1'b1;
			end
			CMD_READ_FAIL: begin
				busy = 1'b0;
				r = report_of(ST_READ_FAIL, end_action(), 1'b1);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			report_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		move_report_t want;
		if (!arst_n) begin
			target = POS_W'(TARGET_RESET);
			lim.reach_tolerance = TOL_RESET;
			lim.high_current_limit = HI_CUR_RESET;
			lim.absolute_current_limit = ABS_CUR_RESET;
			lim.stall_ticks = STALL_RESET;
			lim.high_current_stall_ticks = HI_STALL_RESET;
			lim.move_limit_ticks = MOVE_LIMIT_RESET;
			lim.fault_to_neutral = 1'b1;
			busy = 1'b0;
			moving_up = 1'b0;
			anchor = '0;
			pos_seen = '0;
			peak_seen = '0;
			since_progress = '0;
			since_start = '0;
			pending_reports.delete();
			report_errors = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET:     target = cfg_data[POS_W-1:0];
					REG_TOLERANCE:  lim.reach_tolerance = cfg_data[TOL_BITS-1:0];
					REG_HI_CUR:     lim.high_current_limit = cfg_data;
					REG_ABS_CUR:    lim.absolute_current_limit = cfg_data;
					REG_STALL:      lim.stall_ticks = cfg_data;
					REG_HI_STALL:   lim.high_current_stall_ticks = cfg_data;
					REG_MOVE_LIMIT: lim.move_limit_ticks = cfg_data;
					REG_FAULT_MODE: lim.fault_to_neutral = cfg_data[0];
					default: ;
				endcase
			end
			// result side first, so a report never matches an item taken this edge
			if (res_valid && res_ready) begin
				if (pending_reports.size() == 0) begin
					$display({"%0t: report with nothing expected: status %0d action %0d",
						" peak %0d position %0d done %0b"},
						$time, status, action, peak_current, last_position, done_res);
					report_errors++;
				end else begin
					want = pending_reports.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("action", 32'(want.action), 32'(action));
					check_field("peak_current", 32'(want.peak), 32'(peak_current));
					check_field("last_position", 32'(want.pos), 32'(last_position));
					check_field("done_res", 32'(want.done), 32'(done_res));
				end
			end
			// item side
			if (item_valid && item_ready) begin
				if (supervise_step(cmd, motor_current, position, want))
					pending_reports.push_back(want);
			end
		end
		reports_owed = pending_reports.size();
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus and verdict for actuator_move_stall_guard; drives the
// register, item and result ports, checking is done by move_guard_checker
// depends on amsg_pkg, move_guard_checker and the block itself
module testbench;
	import amsg_pkg::*;

	localparam int POS_W         = POSITION_BITS_DEF;
	localparam int POS_MAX       = (1 << POS_W) - 1;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 32;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      item_valid;
	logic                      item_ready;
	logic [2:0]                cmd;
	logic [CUR_BITS-1:0]       motor_current;
	logic [POS_W-1:0]          position;
	logic                      res_valid;
	logic                      res_ready;
	logic [2:0]                status;
	logic [1:0]                action;
	logic [CUR_BITS-1:0]       peak_current;
	logic [POS_W-1:0]          last_position;
	logic                      done_res;
	int                        reports_owed;
	int                        report_errors;
	int                        cycles;
	int                        sent;
	bit                        steady;

	// register shadow, only used to aim the stimulus
	logic [POS_W-1:0]    aim_target;
	logic [TOL_BITS-1:0] aim_tol;
	logic [CUR_BITS-1:0] aim_hi_cur;
	logic [CUR_BITS-1:0] aim_abs_cur;

	actuator_move_stall_guard DUT (.*);

	move_guard_checker watcher (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("actuator_move_stall_guard verification failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// result side stalls
	initial begin
		int seg;
		res_ready = 1'b0;
		seg = 0;
		forever begin
			@(negedge clk);
			if (steady) begin
				res_ready <= 1'b1;
			end else if (seg > 0) begin
				seg--;
			end else if (res_ready) begin
				seg = pick_gap();
				if (seg > 0)
					res_ready <= 1'b0;
				else
					seg = $urandom_range(0, 10);
			end else begin
				res_ready <= 1'b1;
				seg = $urandom_range(0, 12);
			end
		end
	end

	// one item, entered and left at a falling edge
	task automatic send_item(input logic [2:0] c, input logic [CUR_BITS-1:0] cur,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		motor_current <= cur;
		position <= pos;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		sent++;
	endtask

	// hold off items until every report is in, then let ticks settle
	task automatic drain();
		item_valid <= 1'b0;
		while (reports_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_TARGET:    aim_target = val[POS_W-1:0];
			REG_TOLERANCE: aim_tol = val[TOL_BITS-1:0];
			REG_HI_CUR:    aim_hi_cur = val[CUR_BITS-1:0];
			REG_ABS_CUR:   aim_abs_cur = val[CUR_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input int unsigned tgt, tol, hi, abs_lim, stall, hstall, mlim,
			neutral);
		write_reg(REG_TARGET, tgt);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_HI_CUR, hi);
		write_reg(REG_ABS_CUR, abs_lim);
		write_reg(REG_STALL, stall);
		write_reg(REG_HI_STALL, hstall);
		write_reg(REG_MOVE_LIMIT, mlim);
		write_reg(REG_FAULT_MODE, neutral);
	endtask

	// currents mostly below the high limit, some between the limits, some on them
	function automatic logic [CUR_BITS-1:0] pick_current();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return (aim_hi_cur > 0) ? CUR_BITS'($urandom_range(0, aim_hi_cur - 1)) : '0;
		if (r < 15)
			return CUR_BITS'($urandom_range(aim_hi_cur,
				(aim_abs_cur > aim_hi_cur) ? aim_abs_cur - 1 : aim_hi_cur));
		if (r == 15)
			return aim_hi_cur;
		if (r == 16)
			return aim_abs_cur;
		return CUR_BITS'($urandom_range(0, 65535));
	endfunction

	function automatic logic [POS_W-1:0] pick_start_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return POS_W'(POS_MAX);
		return POS_W'($urandom_range(0, POS_MAX));
	endfunction

	// next feedback position: mostly toward the target, sometimes back or onto it
	function automatic logic [POS_W-1:0] step_toward(input logic [POS_W-1:0] from);
		int p, dir, r, k;
		dir = (aim_target >= from) ? 1 : -1;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			k = $urandom_range(0, 2 * aim_tol + 2);
			p = int'(aim_target) + k - int'(aim_tol) - 1;
		end else if (r < 4) begin
			k = $urandom_range(1, 4);
			p = int'(from) - dir * k;
		end else if (r < 7) begin
			p = int'(from) + dir;
		end else begin
			k = $urandom_range(2, 40);
			p = int'(from) + dir * k;
		end
		if (p < 0)
			p = 0;
		if (p > POS_MAX)
			p = POS_MAX;
		return p[POS_W-1:0];
	endfunction

	// one well-formed move with random content and the odd interruption
	task automatic run_move();
		logic [POS_W-1:0] pos;
		int len, r;
		pos = pick_start_pos();
		send_item(CMD_START, pick_current(), pos);
		len = $urandom_range(3, 16);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				repeat ($urandom_range(1, 6))
					send_item(CMD_TICK, CUR_BITS'($urandom), POS_W'($urandom));
			end else if (r < 88) begin
				pos = step_toward(pos);
				send_item(CMD_SAMPLE, pick_current(), pos);
			end else if (r < 92) begin
				send_item(CMD_ABORT, CUR_BITS'($urandom), POS_W'($urandom));
			end else if (r < 95) begin
				send_item(CMD_READ_FAIL, CUR_BITS'($urandom), POS_W'($urandom));
			end else if (r < 97) begin
				pos = pick_start_pos();
				send_item(CMD_START, pick_current(), pos);
			end else begin
				send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
					CUR_BITS'($urandom), POS_W'($urandom));
			end
		end
	endtask

	initial begin
		int budget_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		cmd = CMD_START;
		motor_current = '0;
		position = '0;
		steady = 1'b0;
		sent = 0;
		aim_target = POS_W'(TARGET_RESET);
		aim_tol = TOL_RESET;
		aim_hi_cur = HI_CUR_RESET;
		aim_abs_cur = ABS_CUR_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle behavior under reset limits
		send_item(CMD_READ_FAIL, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd1234, 12'd2000);
		send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_ABORT, 16'd0, 12'd0);
		send_item(CMD_SPARE_HI, 16'hffff, 12'hfff);
		// field extremes: absolute current, then reached from the top
		send_item(CMD_START, 16'd100, 12'd0);
		send_item(CMD_SAMPLE, 16'hffff, 12'd1);
		send_item(CMD_START, 16'hffff, 12'hfff);
		send_item(CMD_SAMPLE, 16'd0, 12'd2836);
		// restart while busy, reversal on a downward move, read failure while busy
		send_item(CMD_START, 16'd5, 12'd1000);
		send_item(CMD_START, 16'd7, 12'd3000);
		send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd3000, 12'd3001);
		send_item(CMD_READ_FAIL, 16'd0, 12'd0);

		// short tick limits, stop motor on faults
		drain();
		write_reg(REG_STALL, 3);
		write_reg(REG_HI_STALL, 1);
		write_reg(REG_MOVE_LIMIT, 3);
		write_reg(REG_FAULT_MODE, 0);
		// high current stall
		send_item(CMD_START, 16'd0, 12'd100);
		send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd3000, 12'd101);
		// no progress
		send_item(CMD_START, 16'd0, 12'd100);
		repeat (3) send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd0, 12'd101);
		// timeout while progressing
		send_item(CMD_START, 16'd0, 12'd100);
		repeat (2) send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd0, 12'd110);
		send_item(CMD_TICK, 16'd0, 12'd0);
		send_item(CMD_SAMPLE, 16'd0, 12'd120);

		// random phases, each under its own limits
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase == 1)
				set_limits(0, 0, 0, 0, 0, 0, 0, 0);
			else if (phase == 4)
				set_limits(POS_MAX, 255, 65535, 65535, 65535, 65535, 65535, 1);
			else begin
				set_limits($urandom_range(0, POS_MAX), $urandom_range(0, 24),
					$urandom_range(200, 6000), 0, $urandom_range(1, 20),
					$urandom_range(0, 12), $urandom_range(4, 60), $urandom_range(0, 1));
				write_reg(REG_ABS_CUR, aim_hi_cur + $urandom_range(0, 4000));
			end
			steady = (phase == 6);
			budget_end = sent + PHASE_ITEMS;
			while (sent < budget_end) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 5))
						send_item(3'($urandom_range(0, 7)), CUR_BITS'($urandom),
							POS_W'($urandom));
				else
					run_move();
				if ($urandom_range(0, 7) == 0)
					drain();
			end
		end
		steady = 1'b0;
		drain();

		if (report_errors == 0)
			$display("actuator_move_stall_guard verification clean");
		else
			$display("actuator_move_stall_guard verification failed");
		$finish;
	end

endmodule

>>> actuator_move_stall_guard.f
src/amsg_pkg.sv
src/amsg_eval.sv
src/actuator_move_stall_guard.sv
verif/move_guard_checker.sv
verif/testbench.sv
